// ===== design/dbs_pkg.sv =====
// dbs_pkg: shared constants, side codes and latency helpers for the same-side test.
// No dependencies; imported by every module of the block except dbs_delay.
package dbs_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int IN_FIELDS      = 12;
   localparam int MUL_LIMB       = 32;

   localparam int MC_W               = 16;
   localparam logic [MC_W-1:0] MIN_COSINE_RESET = 16'd6554;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_MIN_COSINE = 1'b0;

   localparam int SIDE_W = 2;
   localparam int RSP_W  = 8;
   localparam logic [SIDE_W-1:0] SIDE_NONE = 2'b00;
   localparam logic [SIDE_W-1:0] SIDE_SAME = 2'b01;
   localparam logic [SIDE_W-1:0] SIDE_OPP  = 2'b11;

   typedef struct packed {
      logic deg;
      logic qpos;
      logic below1;
   } flag_type;

   function automatic int imax(input int x, input int y);
      return (x > y) ? x : y;
   endfunction

   // abs stage, two stages per limb of the second operand, sign stage
   function automatic int mul_latency(input int bw);
      return 2 * ((bw + MUL_LIMB - 1) / MUL_LIMB) + 2;
   endfunction

endpackage

// ===== design/double_bond_same_side_test.sv =====
// Same-side test for the two neighbors of a double bond. One word carries four signed
// fixed-point points (beg, end, near, far); the block answers +1 when near and far lie on
// the same side of the bond axis, -1 when on opposite sides, 0 when degenerate or when
// either neighbor is within the min_cosine threshold of the axis. All math is exact
// integer arithmetic with squared comparisons. It takes one word per clock while the two
// output slots are not both full; each result shows on rsp_tvalid after its word has passed
// through a chain of 32-bit-limb multipliers: cross products, dot products, the square of q
// with the threshold scaling, and the last threshold product.
// Two output slots sit at the end, so the pipeline only stalls when both hold results.
// Depends on dbs_pkg, dbs_mul and dbs_delay.
module double_bond_same_side_test import dbs_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // beg_x, beg_y, beg_z, end_x, end_y, end_z, near_x, near_y, near_z, far_x, far_y, far_z
   input  logic [((IN_FIELDS*COORD_BITS+7)/8)*8-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // side
   output logic [RSP_W-1:0]      rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int C        = COORD_BITS;
   localparam int D        = C + 1;
   localparam int PD       = 2 * D;
   localparam int UW       = PD + 1;
   localparam int P2       = 2 * UW;
   localparam int PQ       = P2 + 2;
   localparam int MCW2     = 2 * MC_W + 1;
   localparam int SCALE_SH = 2 * MC_W;
   localparam int R1W      = P2 + MCW2;
   localparam int L1W      = PQ + SCALE_SH;
   localparam int C1W      = imax(R1W, L1W);
   localparam int Q2W      = 2 * PQ;
   localparam int R2AW     = P2 + MCW2;
   localparam int R2W      = R2AW + PQ;
   localparam int L2W      = Q2W + SCALE_SH;
   localparam int C2W      = imax(R2W, L2W);
   localparam int LB       = mul_latency(D);
   localparam int LD       = mul_latency(UW);
   localparam int LM       = mul_latency(MCW2);
   localparam int LQ       = mul_latency(PQ);
   localparam int LF       = imax(LM, LQ);
   localparam int LG       = LQ;
   localparam int LAT      = 3 + LB + LD + LF + LG;

   // ---- configuration ----
   logic [MC_W-1:0]   mc_ff;
   logic [2*MC_W-1:0] mc2_ff;
   logic signed [MCW2-1:0] mc2_s;
   logic              csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (csr_paddr[2] == REG_MIN_COSINE);

   always_ff @(posedge clock) begin
      if (reset) begin
         mc_ff <= MIN_COSINE_RESET;
      end else if (csr_wr) begin
         mc_ff <= csr_pwdata[MC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      mc2_ff <= (2*MC_W)'(mc_ff) * (2*MC_W)'(mc_ff);
   end

   assign mc2_s = {1'b0, mc2_ff};
   assign csr_prdata = (csr_paddr[2] == REG_MIN_COSINE) ? CSR_DATA_W'(mc_ff) : '0;

   // ---- flow control ----
   logic en;
   logic in_go;
   logic last_v;
   logic out_v_ff, skid_v_ff;
   logic [SIDE_W-1:0] out_side_ff, skid_side_ff;
   logic [SIDE_W-1:0] side_in;
   logic push, pop;

   assign en         = !(out_v_ff && skid_v_ff);
   assign req_tready = en;
   assign in_go      = req_tvalid && en;

   dbs_delay #(.W(1), .N(LAT), .CLEAR(1'b1)) u_valid (
      .clock, .reset, .en, .din(in_go), .dout(last_v)
   );

   // ---- stage 1: difference vectors ----
   logic signed [C-1:0] pb [3], pe [3], pn [3], pf [3];
   logic signed [D-1:0] d_in [3], a_in [3], b_in [3];
   logic signed [D-1:0] d_ff [3], a_ff [3], b_ff [3];
   logic                bz_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pb[i]   = req_tdata[i*C +: C];
         pe[i]   = req_tdata[(3+i)*C +: C];
         pn[i]   = req_tdata[(6+i)*C +: C];
         pf[i]   = req_tdata[(9+i)*C +: C];
         d_in[i] = D'(pb[i]) - D'(pe[i]);
         a_in[i] = D'(pn[i]) - D'(pb[i]);
         b_in[i] = D'(pf[i]) - D'(pe[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff  <= d_in;
         a_ff  <= a_in;
         b_ff  <= b_in;
         bz_ff <= (b_in[0] == '0) && (b_in[1] == '0) && (b_in[2] == '0);
      end
   end

   // ---- cross products and squared lengths ----
   logic signed [PD-1:0] dja_m [3], dka_m [3], djb_m [3], dkb_m [3];
   logic signed [PD-1:0] dsq_m [3], asq_m [3], bsq_m [3];
   logic                 bz_b;

   for (genvar gi = 0; gi < 3; gi++) begin : g_cross
      localparam int J = (gi + 1) % 3;
      localparam int K = (gi + 2) % 3;
      dbs_mul #(.AW(D), .BW(D)) u_dja (.clock, .en, .a(d_ff[J]), .b(a_ff[K]), .p(dja_m[gi]));
      dbs_mul #(.AW(D), .BW(D)) u_dka (.clock, .en, .a(d_ff[K]), .b(a_ff[J]), .p(dka_m[gi]));
      dbs_mul #(.AW(D), .BW(D)) u_djb (.clock, .en, .a(d_ff[J]), .b(b_ff[K]), .p(djb_m[gi]));
      dbs_mul #(.AW(D), .BW(D)) u_dkb (.clock, .en, .a(d_ff[K]), .b(b_ff[J]), .p(dkb_m[gi]));
      dbs_mul #(.AW(D), .BW(D)) u_dsq (.clock, .en, .a(d_ff[gi]), .b(d_ff[gi]), .p(dsq_m[gi]));
      dbs_mul #(.AW(D), .BW(D)) u_asq (.clock, .en, .a(a_ff[gi]), .b(a_ff[gi]), .p(asq_m[gi]));
      dbs_mul #(.AW(D), .BW(D)) u_bsq (.clock, .en, .a(b_ff[gi]), .b(b_ff[gi]), .p(bsq_m[gi]));
   end

   dbs_delay #(.W(1), .N(LB)) u_bz (.clock, .reset, .en, .din(bz_ff), .dout(bz_b));

   // ---- stage 2: u = d x a, v = d x b, |d|^2, |a|^2, |b|^2 ----
   logic signed [UW-1:0] u_ff [3], v_ff [3];
   logic signed [UW-1:0] dd_ff, aa_ff, bb_ff;
   logic                 bz2_ff;
   logic                 deg_c;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            u_ff[i] <= UW'(dja_m[i]) - UW'(dka_m[i]);
            v_ff[i] <= UW'(djb_m[i]) - UW'(dkb_m[i]);
         end
         dd_ff  <= UW'(dsq_m[0]) + UW'(dsq_m[1]) + UW'(dsq_m[2]);
         aa_ff  <= UW'(asq_m[0]) + UW'(asq_m[1]) + UW'(asq_m[2]);
         bb_ff  <= UW'(bsq_m[0]) + UW'(bsq_m[1]) + UW'(bsq_m[2]);
         bz2_ff <= bz_b;
      end
   end

   // n = u x d vanishes exactly when u does; a zero a also zeroes u
   assign deg_c = ((u_ff[0] == '0) && (u_ff[1] == '0) && (u_ff[2] == '0)) || bz2_ff;

   // ---- p = a.n = |u|^2, q = b.n = u.v, |a|^2|d|^2, |b|^2|d|^2 ----
   logic signed [P2-1:0] uu_m [3], uv_m [3];
   logic signed [P2-1:0] ad_m, bd_m;
   logic                 deg_d;

   for (genvar gi = 0; gi < 3; gi++) begin : g_dot
      dbs_mul #(.AW(UW), .BW(UW)) u_uu (.clock, .en, .a(u_ff[gi]), .b(u_ff[gi]), .p(uu_m[gi]));
      dbs_mul #(.AW(UW), .BW(UW)) u_uv (.clock, .en, .a(u_ff[gi]), .b(v_ff[gi]), .p(uv_m[gi]));
   end

   dbs_mul #(.AW(UW), .BW(UW)) u_ad (.clock, .en, .a(aa_ff), .b(dd_ff), .p(ad_m));
   dbs_mul #(.AW(UW), .BW(UW)) u_bd (.clock, .en, .a(bb_ff), .b(dd_ff), .p(bd_m));
   dbs_delay #(.W(1), .N(LD)) u_deg (.clock, .reset, .en, .din(deg_c), .dout(deg_d));

   // ---- stage 3 ----
   logic signed [PQ-1:0] p_ff, q_ff;
   logic signed [P2-1:0] ad_ff, bd_ff;
   logic                 deg_ff;
   flag_type             fl_e, fl_f, fl_f2, fl_g;

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff   <= PQ'(uu_m[0]) + PQ'(uu_m[1]) + PQ'(uu_m[2]);
         q_ff   <= PQ'(uv_m[0]) + PQ'(uv_m[1]) + PQ'(uv_m[2]);
         ad_ff  <= ad_m;
         bd_ff  <= bd_m;
         deg_ff <= deg_d;
      end
   end

   always_comb begin
      fl_e        = '0;
      fl_e.deg    = deg_ff;
      fl_e.qpos   = !q_ff[PQ-1] && (q_ff != '0);
      fl_e.below1 = 1'b0;
   end

   // ---- q^2, mc^2 |a|^2 |d|^2, mc^2 |b|^2 |d|^2 ----
   logic signed [Q2W-1:0]  q2_m, q2_f, q2_g;
   logic signed [R1W-1:0]  r1_m, r1_f;
   logic signed [R2AW-1:0] r2a_m, r2a_f;
   logic signed [PQ-1:0]   p_f;
   logic [C1W-1:0]         lhs1, rhs1x;

   dbs_mul #(.AW(PQ), .BW(PQ)) u_q2 (.clock, .en, .a(q_ff), .b(q_ff), .p(q2_m));
   dbs_mul #(.AW(P2), .BW(MCW2)) u_r1 (.clock, .en, .a(ad_ff), .b(mc2_s), .p(r1_m));
   dbs_mul #(.AW(P2), .BW(MCW2)) u_r2a (.clock, .en, .a(bd_ff), .b(mc2_s), .p(r2a_m));

   dbs_delay #(.W(Q2W), .N(LF - LQ)) u_q2d (.clock, .reset, .en, .din(q2_m), .dout(q2_f));
   dbs_delay #(.W(R1W), .N(LF - LM)) u_r1d (.clock, .reset, .en, .din(r1_m), .dout(r1_f));
   dbs_delay #(.W(R2AW), .N(LF - LM)) u_r2ad (.clock, .reset, .en, .din(r2a_m), .dout(r2a_f));
   dbs_delay #(.W(PQ), .N(LF)) u_pd (.clock, .reset, .en, .din(p_ff), .dout(p_f));
   dbs_delay #(.W($bits(flag_type)), .N(LF)) u_fle (
      .clock, .reset, .en, .din(fl_e), .dout(fl_f)
   );

   // first neighbor: p * 2^32 < mc^2 |a|^2 |d|^2 (|n|^2 = |d|^2 p, one p divided out)
   assign lhs1 = C1W'($unsigned(p_f)) << SCALE_SH;
   assign rhs1x = C1W'($unsigned(r1_f));

   always_comb begin
      fl_f2        = fl_f;
      fl_f2.below1 = lhs1 < rhs1x;
   end

   // ---- mc^2 |b|^2 |d|^2 p ----
   logic signed [R2W-1:0] r2_m;
   logic [C2W-1:0]        lhs2, rhs2x;
   logic                  below2;

   dbs_mul #(.AW(R2AW), .BW(PQ)) u_r2 (.clock, .en, .a(r2a_f), .b(p_f), .p(r2_m));
   dbs_delay #(.W(Q2W), .N(LG)) u_q2g (.clock, .reset, .en, .din(q2_f), .dout(q2_g));
   dbs_delay #(.W($bits(flag_type)), .N(LG)) u_flf (
      .clock, .reset, .en, .din(fl_f2), .dout(fl_g)
   );

   assign lhs2   = C2W'($unsigned(q2_g)) << SCALE_SH;
   assign rhs2x  = C2W'($unsigned(r2_m));
   assign below2 = lhs2 < rhs2x;

   always_comb begin
      if (fl_g.deg || fl_g.below1 || below2) begin
         side_in = SIDE_NONE;
      end else if (fl_g.qpos) begin
         side_in = SIDE_SAME;
      end else begin
         side_in = SIDE_OPP;
      end
   end

   // ---- two-slot output buffer ----
   assign push = en && last_v;
   assign pop  = out_v_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!out_v_ff || pop) begin
         if (skid_v_ff) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= push;
         end else begin
            out_v_ff  <= push;
         end
      end else if (push) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || pop) begin
         if (skid_v_ff) begin
            out_side_ff  <= skid_side_ff;
            skid_side_ff <= side_in;
         end else begin
            out_side_ff  <= side_in;
         end
      end else if (push) begin
         skid_side_ff <= side_in;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = RSP_W'(out_side_ff);

endmodule

// ===== design/dbs_delay.sv =====
// dbs_delay: enable-gated delay line of N stages, optionally cleared by reset.
// No package dependencies.
module dbs_delay #(
   parameter int W     = 1,
   parameter int N     = 1,
   parameter bit CLEAR = 1'b0
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);

   if (N == 0) begin : g_pass
      assign dout = din;
   end else begin : g_line
      logic [W-1:0] tap_ff [N];

      always_ff @(posedge clock) begin
         if (CLEAR && reset) begin
            for (int i = 0; i < N; i++) tap_ff[i] <= '0;
         end else if (en) begin
            tap_ff[0] <= din;
            for (int i = 1; i < N; i++) tap_ff[i] <= tap_ff[i-1];
         end
      end

      assign dout = tap_ff[N-1];
   end

endmodule

// ===== design/dbs_mul.sv =====
// dbs_mul: pipelined signed multiplier built from MUL_LIMB x MUL_LIMB partial products,
// one limb of b per two stages.
module dbs_mul import dbs_pkg::*; #(
   parameter int AW = 17,
   parameter int BW = 17
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic signed [AW-1:0]  a,
   input  logic signed [BW-1:0]  b,
   output logic signed [AW+BW-1:0] p
);

   localparam int L  = MUL_LIMB;
   localparam int NA = (AW + L - 1) / L;
   localparam int NB = (BW + L - 1) / L;
   localparam int RW = AW + BW;
   localparam int PW = (NA + 1) * L;

   logic signed [AW-1:0] a_neg;
   logic signed [BW-1:0] b_neg;
   logic [AW-1:0]        a_mag;
   logic [BW-1:0]        b_mag;

   logic [NA*L-1:0] a0_ff;
   logic [NB*L-1:0] b0_ff;
   logic            n0_ff;

   logic [NA*L-1:0] a_src [NB];
   logic [NB*L-1:0] b_src [NB];
   logic            n_src [NB];
   logic [RW-1:0]   acc_src [NB];

   logic [NA*L-1:0] ap_ff [NB];
   logic [NB*L-1:0] bp_ff [NB];
   logic            np_ff [NB];
   logic [RW-1:0]   accp_ff [NB];
   logic [PW-1:0]   ev_ff [NB];
   logic [PW-1:0]   od_ff [NB];
   logic [PW-1:0]   ev_in [NB];
   logic [PW-1:0]   od_in [NB];

   logic [NA*L-1:0] aq_ff [NB];
   logic [NB*L-1:0] bq_ff [NB];
   logic            nq_ff [NB];
   logic [RW-1:0]   accq_ff [NB];
   logic [RW-1:0]   accq_in [NB];

   logic [RW-1:0]   p_ff;

   assign a_neg = -a;
   assign b_neg = -b;
   assign a_mag = a[AW-1] ? a_neg : a;
   assign b_mag = b[BW-1] ? b_neg : b;

   always_ff @(posedge clock) begin
      if (en) begin
         a0_ff <= (NA*L)'(a_mag);
         b0_ff <= (NB*L)'(b_mag);
         n0_ff <= a[AW-1] ^ b[BW-1];
      end
   end

   always_comb begin
      a_src[0]   = a0_ff;
      b_src[0]   = b0_ff;
      n_src[0]   = n0_ff;
      acc_src[0] = '0;
      for (int k = 1; k < NB; k++) begin
         a_src[k]   = aq_ff[k-1];
         b_src[k]   = bq_ff[k-1];
         n_src[k]   = nq_ff[k-1];
         acc_src[k] = accq_ff[k-1];
      end
   end

   // even and odd limb products never overlap among themselves
   always_comb begin
      logic [2*L-1:0] pp;
      for (int k = 0; k < NB; k++) begin
         ev_in[k] = '0;
         od_in[k] = '0;
         for (int i = 0; i < NA; i++) begin
            pp = (2*L)'(a_src[k][i*L +: L]) * (2*L)'(b_src[k][k*L +: L]);
            if (i % 2 == 0) ev_in[k][i*L +: 2*L] = pp;
            else            od_in[k][i*L +: 2*L] = pp;
         end
      end
   end

   always_comb begin
      for (int k = 0; k < NB; k++) begin
         accq_in[k] = accp_ff[k] + (RW'(ev_ff[k]) << (k*L)) + (RW'(od_ff[k]) << (k*L));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NB; k++) begin
            ap_ff[k]   <= a_src[k];
            bp_ff[k]   <= b_src[k];
            np_ff[k]   <= n_src[k];
            accp_ff[k] <= acc_src[k];
            ev_ff[k]   <= ev_in[k];
            od_ff[k]   <= od_in[k];
            aq_ff[k]   <= ap_ff[k];
            bq_ff[k]   <= bp_ff[k];
            nq_ff[k]   <= np_ff[k];
            accq_ff[k] <= accq_in[k];
         end
         p_ff <= nq_ff[NB-1] ? (-accq_ff[NB-1]) : accq_ff[NB-1];
      end
   end

   assign p = p_ff;

endmodule

// ===== tb/sv/double_bond_same_side_test_tb.sv =====
// Self-checking testbench for double_bond_same_side_test: a directed table, then random
// point sets under several min_cosine settings, checked against an exact-integer predictor.
// Depends on dbs_pkg and the double_bond_same_side_test RTL.
module double_bond_same_side_test_tb import dbs_pkg::*; ();

   localparam int CW          = COORD_BITS_DEF;
   localparam int REQ_W       = ((IN_FIELDS*CW+7)/8)*8;
   localparam int LATENCY     = 40;
   localparam int CYCLE_LIMIT = 400000;
   localparam int NUM_PHASES  = 6;
   localparam int RANDOM_PER_PHASE = 171;
   localparam int NUM_ROWS    = 21;
   localparam int IDLE_PCT    = 21;
   localparam int PMAX        = 32767;
   localparam int PMIN        = -32768;
   // table column that holds no typed side; the predictor supplies it
   localparam int PREDICTED   = -1;
   localparam logic [CSR_ADDR_W-1:0] MC_ADDR    = CSR_ADDR_W'(4 * int'(REG_MIN_COSINE));
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = MC_ADDR + CSR_ADDR_W'(4);

   typedef logic signed [CW-1:0]  coord_type;
   typedef logic signed [255:0]   wide_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   logic [MC_W-1:0]       threshold = MIN_COSINE_RESET;
   logic [SIDE_W-1:0]     pending_sides [$];
   logic                  steady = 1'b0;
   int                    errors = 0;
   int                    cycles = 0;

   // 12 coordinates (beg, end, near, far; x y z each) and the typed side
   int dir_rows [NUM_ROWS][13] = '{
      '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, SIDE_NONE},
      '{256, 256, 256, 256, 256, 256, 0, 0, 0, 512, 0, 0, SIDE_NONE},
      '{0, 0, 0, 256, 0, 0, 0, 0, 0, 256, 256, 0, SIDE_NONE},
      '{0, 0, 0, 256, 0, 0, 0, 256, 0, 256, 0, 0, SIDE_NONE},
      '{0, 0, 0, 256, 0, 0, -512, 0, 0, 256, 256, 0, SIDE_NONE},
      '{0, 0, 0, 256, 0, 0, 0, 256, 0, 256, 256, 0, SIDE_SAME},
      '{0, 0, 0, 256, 0, 0, 0, 256, 0, 256, -256, 0, SIDE_OPP},
      '{0, 0, 0, 256, 0, 0, -2560, 16, 0, 256, 256, 0, SIDE_NONE},
      '{0, 0, 0, 256, 0, 0, -256, 64, 0, 256, 256, 0, PREDICTED},
      '{0, 0, 0, 256, 0, 0, 0, 256, 0, 256, 0, 256, SIDE_NONE},
      '{0, 0, 0, 0, 0, 256, 256, 0, 0, -256, 0, 256, PREDICTED},
      '{PMAX, PMAX, PMAX, PMIN, PMIN, PMIN, PMIN, PMAX, PMIN, PMAX, PMIN, PMAX, PREDICTED},
      '{PMIN, PMIN, PMIN, PMAX, PMAX, PMAX, PMAX, PMIN, PMIN, PMIN, PMAX, PMAX, PREDICTED},
      '{PMIN, 0, PMAX, PMAX, 0, PMIN, PMIN, PMAX, PMAX, PMAX, PMIN, PMIN, PREDICTED},
      '{PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, SIDE_NONE},
      '{PMIN, PMIN, PMIN, PMIN, PMIN, PMIN, PMIN, PMIN, PMIN, PMIN, PMIN, PMIN, SIDE_NONE},
      '{PMAX, PMAX, PMAX, 0, 0, 0, PMIN, PMIN, PMIN, PMAX, PMIN, 0, PREDICTED},
      '{0, 0, 0, 1, 0, 0, 0, 1, 0, 1, -1, 0, PREDICTED},
      '{1, 1, 1, -1, -1, -1, 2, 1, 1, -1, -2, -1, PREDICTED},
      '{0, 0, 0, 256, 0, 0, 0, 256, 0, 512, 0, 0, PREDICTED},
      '{-1000, 2000, -3000, 4000, -5000, 6000, -7000, 8000, 9000, 10000, -11000, 12000,
        PREDICTED}
   };

   double_bond_same_side_test DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // exact side of near and far relative to the bond axis, squared threshold compare
   function automatic logic [SIDE_W-1:0] predict_side(input logic [REQ_W-1:0] word,
                                                     input logic [MC_W-1:0] mc);
      coord_type pb, pe, pn, pf;
      wide_type  d [3];
      wide_type  a [3];
      wide_type  b [3];
      wide_type  c [3];
      wide_type  n [3];
      wide_type  p, q, aa, bb, nn, mcw, mc2;
      int        k;
      for (k = 0; k < 3; k++) begin
         pb = word[CW*k +: CW];
         pe = word[CW*(3+k) +: CW];
         pn = word[CW*(6+k) +: CW];
         pf = word[CW*(9+k) +: CW];
         d[k] = pb - pe;
         a[k] = pn - pb;
         b[k] = pf - pe;
      end
      c[0] = d[1]*a[2] - d[2]*a[1];
      c[1] = d[2]*a[0] - d[0]*a[2];
      c[2] = d[0]*a[1] - d[1]*a[0];
      n[0] = c[1]*d[2] - c[2]*d[1];
      n[1] = c[2]*d[0] - c[0]*d[2];
      n[2] = c[0]*d[1] - c[1]*d[0];
      if ((n[0] == 0 && n[1] == 0 && n[2] == 0) || (a[0] == 0 && a[1] == 0 && a[2] == 0) ||
          (b[0] == 0 && b[1] == 0 && b[2] == 0))
         return SIDE_NONE;
      p   = a[0]*n[0] + a[1]*n[1] + a[2]*n[2];
      q   = b[0]*n[0] + b[1]*n[1] + b[2]*n[2];
      aa  = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
      bb  = b[0]*b[0] + b[1]*b[1] + b[2]*b[2];
      nn  = n[0]*n[0] + n[1]*n[1] + n[2]*n[2];
      mcw = {{(256-MC_W){1'b0}}, mc};
      mc2 = mcw * mcw;
      if (((p*p) <<< 32) < mc2*aa*nn || ((q*q) <<< 32) < mc2*bb*nn)
         return SIDE_NONE;
      if (p != 0 && q != 0 && ((p < 0) == (q < 0)))
         return SIDE_SAME;
      return SIDE_OPP;
   endfunction

   // plausible bond geometry for half the words, with raw noise and tiny coordinates mixed in
   function automatic logic [REQ_W-1:0] random_word();
      logic [REQ_W-1:0] w;
      int pt [12];
      int axis [3];
      int mode, k, s;
      mode = $urandom_range(0, 9);
      s = $urandom_range(0, 4);
      for (k = 0; k < 12; k++) pt[k] = $urandom;
      if (mode == 3 || mode == 4) begin
         for (k = 0; k < 12; k++) pt[k] = int'($urandom_range(0, 8)) - 4;
      end else if (mode >= 5) begin
         for (k = 0; k < 3; k++) begin
            pt[k]     = int'($urandom_range(0, 32000)) - 16000;
            axis[k]   = int'($urandom_range(0, 8192)) - 4096;
            pt[3+k]   = pt[k] - axis[k];
            pt[6+k]   = pt[k] + int'($urandom_range(0, 8192)) - 4096;
            pt[9+k]   = pt[3+k] + int'($urandom_range(0, 8192)) - 4096;
            // neighbors close to the axis, around the usual thresholds
            if (mode == 8) begin
               pt[6+k] = pt[k] + axis[k] + int'($urandom_range(0, 1024)) - 512;
               pt[9+k] = pt[3+k] - axis[k] + int'($urandom_range(0, 1024)) - 512;
            end
            if (mode == 9) begin
               case (s)
                  0: pt[6+k] = pt[k];
                  1: pt[9+k] = pt[3+k];
                  2: pt[3+k] = pt[k];
                  3: pt[6+k] = pt[k] + axis[k] + int'($urandom_range(0, 2)) - 1;
                  default: pt[9+k] = pt[3+k] - axis[k]/2 + int'($urandom_range(0, 16)) - 8;
               endcase
            end
         end
      end
      for (k = 0; k < 12; k++) w[CW*k +: CW] = pt[k][CW-1:0];
      return w;
   endfunction

   function automatic logic [MC_W-1:0] phase_threshold(input int ph);
      case (ph)
         1: return '0;
         2: return '1;
         3: return MC_W'(1);
         4: return MC_W'($urandom_range(0, 65535));
         5: return MC_W'(32768);
         default: return MIN_COSINE_RESET;
      endcase
   endfunction

   task automatic send_word(input logic [REQ_W-1:0] word, input logic [SIDE_W-1:0] side);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_sides.push_back(side);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == MC_ADDR) threshold = data[MC_W-1:0];
      @(posedge clock);
   endtask

   task automatic csr_check();
      logic [CSR_DATA_W-1:0] got;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= MC_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      while (!csr_pready) @(negedge clock);
      got = csr_prdata;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== CSR_DATA_W'(threshold)) begin
         $display("%0t: min_cosine readback mismatch, expected %0d actual %0d",
                  $time, threshold, got);
         errors++;
      end
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_sides.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      logic [SIDE_W-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_sides.size() == 0) begin
            $display("%0t: unexpected word, expected none actual %0d",
                     $time, $signed(rsp_tdata[SIDE_W-1:0]));
            errors++;
         end else begin
            want = pending_sides.pop_front();
            if (rsp_tdata[SIDE_W-1:0] !== want) begin
               $display("%0t: side mismatch, expected %0d actual %0d",
                        $time, $signed(want), $signed(rsp_tdata[SIDE_W-1:0]));
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("double_bond_same_side_test verification failed");
         $finish;
      end
   end

   initial begin
      logic [REQ_W-1:0]  word;
      logic [SIDE_W-1:0] side;
      int r, k, ph, i;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_check();
      for (ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph > 0) begin
            wait_drained();
            csr_write(MC_ADDR, CSR_DATA_W'(phase_threshold(ph)));
            // writes past the last register must leave min_cosine alone
            if (ph == 2) csr_write(SPARE_ADDR, '1);
            csr_check();
         end
         steady <= (ph == 3);
         for (r = 0; r < NUM_ROWS; r++) begin
            for (k = 0; k < 12; k++) word[CW*k +: CW] = dir_rows[r][k][CW-1:0];
            if (ph == 0 && dir_rows[r][12] != PREDICTED)
               side = dir_rows[r][12][SIDE_W-1:0];
            else
               side = predict_side(word, threshold);
            send_word(word, side);
         end
         for (i = 0; i < RANDOM_PER_PHASE; i++) begin
            word = random_word();
            send_word(word, predict_side(word, threshold));
         end
      end
      wait_drained();
      if (errors == 0) begin
         $display("double_bond_same_side_test verification clean");
      end else begin
         $display("double_bond_same_side_test verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/dbs_pkg.sv
design/dbs_delay.sv
design/dbs_mul.sv
design/double_bond_same_side_test.sv
tb/sv/double_bond_same_side_test_tb.sv
